// ===== src/tsfp_pkg.sv =====
// Shared types and constants for the two-type serial frame parser.
package tsfp_pkg;

  // Frame lengths in bytes, start, type and checksum bytes included.
  localparam int MOTION_FRAME_LEN = 15;
  localparam int STATUS_FRAME_LEN = 13;

  // Body store depth and the body length of each frame type.
  localparam int BODY_DEPTH = 12;
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] MOTION_BODY_LEN = POS_W'(MOTION_FRAME_LEN - 3);
  localparam logic [POS_W-1:0] STATUS_BODY_LEN = POS_W'(STATUS_FRAME_LEN - 3);

  // Frame kind codes.
  localparam logic KIND_MOTION = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_BYTE  = 2'd0;
  localparam logic [1:0] REG_MOTION_TYPE = 2'd1;
  localparam logic [1:0] REG_STATUS_TYPE = 2'd2;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_TYPE,
    PH_BODY
  } phase_t;

  // Configuration values seen by the parser.
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] motion_type_code;
    logic [7:0] status_type_code;
  } cfg_t;

  // One parsed frame result.
  typedef struct packed {
    logic        frame_kind;
    logic        sum_good;
    logic [15:0] left_speed;
    logic [15:0] right_speed;
    logic [15:0] heading;
    logic [15:0] turn_rate;
    logic [31:0] sonar_ranges;
    logic [55:0] status_bytes;
    logic [23:0] spare_bytes;
  } result_t;

endpackage

// ===== src/tsfp_parse.sv =====
// Byte-level frame parser: phase tracking, body store, checksum and result forming.
module tsfp_parse (
  input  logic                     clk,
  input  logic                     rst,
  input  tsfp_pkg::cfg_t           cfg,
  input  logic                     byte_take,
  input  logic [7:0]               rx_byte,
  output logic                     res_valid,
  output tsfp_pkg::result_t        res
);

  tsfp_pkg::phase_t                 phase;
  tsfp_pkg::phase_t                 phase_next;
  logic [tsfp_pkg::POS_W-1:0]       byte_position;
  logic                             current_kind;
  logic [7:0]                       running_sum;
  logic [7:0]                       body_bytes [tsfp_pkg::BODY_DEPTH];
  logic [63:0]                      held_motion;
  logic [31:0]                      held_sonar;
  logic [63:0]                      held_motion_next;
  logic [31:0]                      held_sonar_next;

  logic [tsfp_pkg::POS_W-1:0]       body_len;
  logic                             is_motion_type;
  logic                             is_status_type;
  logic                             is_start;
  logic                             in_body;
  logic                             is_last;
  logic                             good;
  logic [8*tsfp_pkg::BODY_DEPTH-1:0] body_flat;

  // Byte classification against the configured codes.
  assign is_start       = (rx_byte == cfg.start_byte);
  assign is_motion_type = (rx_byte == cfg.motion_type_code);
  assign is_status_type = (rx_byte == cfg.status_type_code);
  assign body_len       = current_kind ? tsfp_pkg::STATUS_BODY_LEN
                                       : tsfp_pkg::MOTION_BODY_LEN;
  assign in_body        = (phase == tsfp_pkg::PH_BODY) && (byte_position < body_len);
  assign is_last        = (phase == tsfp_pkg::PH_BODY) && (byte_position >= body_len);
  assign good           = (rx_byte == running_sum);

  // Flatten the body store, first byte in the low bits.
  for (genvar g = 0; g < tsfp_pkg::BODY_DEPTH; g++) begin : g_flat
    assign body_flat[8*g +: 8] = body_bytes[g];
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    case (phase)
      tsfp_pkg::PH_HUNT: begin
        if (byte_take && is_start) phase_next = tsfp_pkg::PH_TYPE;
      end
      tsfp_pkg::PH_TYPE: begin
        if (byte_take) begin
          if (is_motion_type || is_status_type) phase_next = tsfp_pkg::PH_BODY;
          else if (!is_start) phase_next = tsfp_pkg::PH_HUNT;
        end
      end
      tsfp_pkg::PH_BODY: begin
        if (byte_take && is_last) phase_next = tsfp_pkg::PH_HUNT;
      end
      default: phase_next = tsfp_pkg::PH_HUNT;
    endcase
  end

  // Held motion values follow a good motion frame.
  always_comb begin
    held_motion_next = held_motion;
    held_sonar_next  = held_sonar;
    if (current_kind == tsfp_pkg::KIND_MOTION && good) begin
      held_motion_next = body_flat[63:0];
      held_sonar_next  = body_flat[95:64];
    end
  end

  // Result forming for the checksum byte.
  always_comb begin
    res_valid        = byte_take && is_last;
    res              = '0;
    res.frame_kind   = current_kind;
    res.sum_good     = good;
    if (current_kind == tsfp_pkg::KIND_MOTION) begin
      res.left_speed   = held_motion_next[15:0];
      res.right_speed  = held_motion_next[31:16];
      res.heading      = held_motion_next[47:32];
      res.turn_rate    = held_motion_next[63:48];
      res.sonar_ranges = held_sonar_next;
    end else if (good) begin
      res.status_bytes = body_flat[55:0];
      res.spare_bytes  = body_flat[79:56];
    end
  end

  // Phase register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tsfp_pkg::PH_HUNT;
    end else begin
      phase <= phase_next;
    end
  end

  // Position, kind, running sum and held values.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      current_kind  <= tsfp_pkg::KIND_MOTION;
      running_sum   <= '0;
      held_motion   <= '0;
      held_sonar    <= '0;
    end else if (byte_take) begin
      case (phase)
        tsfp_pkg::PH_HUNT: begin
          if (is_start) running_sum <= rx_byte;
        end
        tsfp_pkg::PH_TYPE: begin
          if (is_motion_type || is_status_type) begin
            current_kind  <= is_motion_type ? tsfp_pkg::KIND_MOTION : tsfp_pkg::KIND_STATUS;
            running_sum   <= running_sum + rx_byte;
            byte_position <= '0;
          end else if (is_start) begin
            running_sum <= rx_byte;
          end
        end
        tsfp_pkg::PH_BODY: begin
          if (in_body) begin
            running_sum   <= running_sum + rx_byte;
            byte_position <= byte_position + 1'b1;
          end else begin
            byte_position <= '0;
            held_motion   <= held_motion_next;
            held_sonar    <= held_sonar_next;
          end
        end
        default: ;
      endcase
    end
  end

  // Body store; entries are always written before they are read in a frame.
  always_ff @(posedge clk) begin
    if (byte_take && in_body) begin
      body_bytes[byte_position] <= rx_byte;
    end
  end

endmodule

// ===== src/two_type_serial_frame_parser_unit.sv =====
// Top level of the two-type serial frame parser.
//
// Serial bytes enter on the input channel (in_valid, in_stall, rx_byte); a byte
// is transferred when in_valid is high and in_stall is low. The parser hunts for
// the start byte, reads the type byte, stores the body and checks the last byte
// against the 8-bit sum of all earlier bytes of the frame. Each complete frame
// gives one result on the output channel (out_valid, out_stall and the result
// fields), which transfers when out_valid is high and out_stall is low.
// One byte is taken per cycle while in_stall is low. A result goes to the result
// register, or to the skid entry if the register holds one not yet taken.
// The two decouple the sides: in_stall rises only when both hold a result, so
// bytes keep flowing while a result waits, and a stalled result holds its value.
// The three configuration registers are written over cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high and unknown indexes are
// ignored. Synchronous reset returns the parser to hunting, clears the held
// motion values, empties the output and loads the default register values.
module two_type_serial_frame_parser_unit (
  input  logic               clk,
  input  logic               rst,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  // Byte input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  // Result output channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic               frame_kind,
  output logic               sum_good,
  output logic signed [15:0] left_speed,
  output logic signed [15:0] right_speed,
  output logic signed [15:0] heading,
  output logic signed [15:0] turn_rate,
  output logic [31:0]        sonar_ranges,
  output logic [55:0]        status_bytes,
  output logic [23:0]        spare_bytes
);

  tsfp_pkg::cfg_t    cfg;
  tsfp_pkg::result_t res;
  tsfp_pkg::result_t out_res;
  tsfp_pkg::result_t skid_res;
  logic              res_valid;
  logic              skid_valid;
  logic              byte_take;
  logic              out_take;

  // Handshake terms.
  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign byte_take = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte       <= 8'd0;
      cfg.motion_type_code <= 8'd1;
      cfg.status_type_code <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsfp_pkg::REG_START_BYTE:  cfg.start_byte       <= cfg_data;
        tsfp_pkg::REG_MOTION_TYPE: cfg.motion_type_code <= cfg_data;
        tsfp_pkg::REG_STATUS_TYPE: cfg.status_type_code <= cfg_data;
        default: ;
      endcase
    end
  end

  tsfp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .byte_take (byte_take),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register and skid entry control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) skid_valid <= 1'b0;
    end else if (res_valid) begin
      if (out_valid && !out_take) skid_valid <= 1'b1;
      else out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Result and skid payload.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_res <= skid_res;
    end else if (res_valid) begin
      if (out_valid && !out_take) skid_res <= res;
      else out_res <= res;
    end
  end

  // Result fields.
  assign frame_kind   = out_res.frame_kind;
  assign sum_good     = out_res.sum_good;
  assign left_speed   = $signed(out_res.left_speed);
  assign right_speed  = $signed(out_res.right_speed);
  assign heading      = $signed(out_res.heading);
  assign turn_rate    = $signed(out_res.turn_rate);
  assign sonar_ranges = out_res.sonar_ranges;
  assign status_bytes = out_res.status_bytes;
  assign spare_bytes  = out_res.spare_bytes;

endmodule

// ===== src/tsfp_checker.sv =====
// Port-level checks for the two-type serial frame parser and their binding.
module tsfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        frame_kind,
  input logic        sum_good,
  input logic [55:0] status_bytes,
  input logic [23:0] spare_bytes
);

  // Reset leaves no result pending.
  property p_reset_empty;
    @(posedge clk) rst |=> !out_valid;
  endproperty
  a_reset_empty: assert property (p_reset_empty)
    else $error("result pending after reset");

  // A stalled result is not dropped.
  property p_hold_valid;
    @(posedge clk) disable iff (rst) (out_valid && out_stall) |=> out_valid;
  endproperty
  a_hold_valid: assert property (p_hold_valid)
    else $error("stalled result dropped");

  // A result transfer always frees the input side in the next cycle.
  property p_stall_release;
    @(posedge clk) disable iff (rst) (out_valid && !out_stall) |=> !in_stall;
  endproperty
  a_stall_release: assert property (p_stall_release)
    else $error("input still stalled after a result transfer");

  // Motion results and failed status results carry no status bytes.
  property p_status_zero;
    @(posedge clk) disable iff (rst)
      (out_valid && (!frame_kind || !sum_good)) |-> (status_bytes == '0 && spare_bytes == '0);
  endproperty
  a_status_zero: assert property (p_status_zero)
    else $error("status bytes not zero");

endmodule

bind two_type_serial_frame_parser_unit tsfp_checker u_tsfp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .frame_kind   (frame_kind),
  .sum_good     (sum_good),
  .status_bytes (status_bytes),
  .spare_bytes  (spare_bytes)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the two-type serial frame parser unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index past the end of the register list; writes to it are ignored.
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int GAP_MAX = 13;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 400;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [7:0]         cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic               frame_kind;
  logic               sum_good;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic signed [15:0] heading;
  logic signed [15:0] turn_rate;
  logic [31:0]        sonar_ranges;
  logic [55:0]        status_bytes;
  logic [23:0]        spare_bytes;

  // Predicted parser state and register contents.
  tsfp_pkg::cfg_t   regs_m;
  tsfp_pkg::phase_t scan_phase;
  logic [3:0]       body_pos;
  logic             cur_kind;
  logic [7:0]       sum_acc;
  logic [7:0]       body_buf [tsfp_pkg::BODY_DEPTH];
  logic [63:0]      last_motion;
  logic [31:0]      last_sonar;

  // Frame results still to come out of the block, oldest first.
  tsfp_pkg::result_t expected_frames [$];
  tsfp_pkg::result_t want_frame;

  int mismatch_total = 0;
  int bytes_sent = 0;
  int hold_cycles = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  two_type_serial_frame_parser_unit DUT (.*);

  // Clock generation.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Predict the effect of one transferred byte, queuing a result at each checksum byte.
  function void parse_byte(input logic [7:0] b);
    tsfp_pkg::result_t r;
    logic [3:0]        body_len;
    body_len = (cur_kind == tsfp_pkg::KIND_STATUS) ? tsfp_pkg::STATUS_BODY_LEN
                                                   : tsfp_pkg::MOTION_BODY_LEN;
    case (scan_phase)
      tsfp_pkg::PH_HUNT: begin
        if (b == regs_m.start_byte) begin
          scan_phase = tsfp_pkg::PH_TYPE;
          sum_acc = b;
        end
      end
      tsfp_pkg::PH_TYPE: begin
        if (b == regs_m.motion_type_code || b == regs_m.status_type_code) begin
          // The motion code wins when both codes match.
          cur_kind = (b == regs_m.motion_type_code) ? tsfp_pkg::KIND_MOTION
                                                    : tsfp_pkg::KIND_STATUS;
          sum_acc = sum_acc + b;
          body_pos = '0;
          scan_phase = tsfp_pkg::PH_BODY;
        end else if (b == regs_m.start_byte) begin
          sum_acc = b;
        end else begin
          scan_phase = tsfp_pkg::PH_HUNT;
        end
      end
      default: begin
        if (body_pos < body_len) begin
          body_buf[body_pos] = b;
          sum_acc = sum_acc + b;
          body_pos = body_pos + 4'd1;
        end else begin
          r = '0;
          r.frame_kind = cur_kind;
          r.sum_good = (b == sum_acc);
          scan_phase = tsfp_pkg::PH_HUNT;
          body_pos = '0;
          if (cur_kind == tsfp_pkg::KIND_MOTION) begin
            // Only a good motion frame refreshes the held values.
            if (r.sum_good) begin
              for (int k = 0; k < 8; k++) last_motion[8*k +: 8] = body_buf[k];
              for (int k = 0; k < 4; k++) last_sonar[8*k +: 8] = body_buf[8+k];
            end
            r.left_speed   = last_motion[15:0];
            r.right_speed  = last_motion[31:16];
            r.heading      = last_motion[47:32];
            r.turn_rate    = last_motion[63:48];
            r.sonar_ranges = last_sonar;
          end else if (r.sum_good) begin
            for (int k = 0; k < 7; k++) r.status_bytes[8*k +: 8] = body_buf[k];
            for (int k = 0; k < 3; k++) r.spare_bytes[8*k +: 8] = body_buf[7+k];
          end
          expected_frames.push_back(r);
        end
      end
    endcase
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_total++;
    if (mismatch_total <= 40) begin
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    end
  endtask

  task automatic compare_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Offer one byte after a random gap and hold it until the transfer.
  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = in_idle_on ? $urandom_range(GAP_MAX, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= value;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    parse_byte(value);
  endtask

  // Send a whole frame of the given kind under the current registers.
  task automatic send_frame(input logic kind,
                            input logic [7:0] body [tsfp_pkg::BODY_DEPTH],
                            input bit corrupt);
    logic [7:0] csum;
    logic [7:0] tcode;
    int         n;
    tcode = (kind == tsfp_pkg::KIND_STATUS) ? regs_m.status_type_code
                                            : regs_m.motion_type_code;
    n = (kind == tsfp_pkg::KIND_STATUS) ? tsfp_pkg::STATUS_BODY_LEN
                                        : tsfp_pkg::MOTION_BODY_LEN;
    csum = regs_m.start_byte + tcode;
    send_byte(regs_m.start_byte);
    send_byte(tcode);
    for (int i = 0; i < n; i++) begin
      send_byte(body[i]);
      csum = csum + body[i];
    end
    if (corrupt) begin
      csum = csum + 8'($urandom_range(255, 1));
    end
    send_byte(csum);
  endtask

  // Random body content, leaning toward the extremes and the start byte.
  function automatic void random_body(output logic [7:0] body [tsfp_pkg::BODY_DEPTH]);
    int pick;
    for (int i = 0; i < tsfp_pkg::BODY_DEPTH; i++) begin
      pick = $urandom_range(9, 0);
      body[i] = (pick == 0) ? 8'h00 :
                (pick == 1) ? 8'hFF :
                (pick == 2) ? regs_m.start_byte : 8'($urandom);
    end
  endfunction

  // Stop offering bytes and let every pending result drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers, then poke the unused index.
  task automatic set_config(input logic [7:0] sb, input logic [7:0] mt,
                            input logic [7:0] st);
    logic [1:0] idx [4];
    logic [7:0] val [4];
    idx = '{tsfp_pkg::REG_START_BYTE, tsfp_pkg::REG_MOTION_TYPE,
            tsfp_pkg::REG_STATUS_TYPE, REG_NONE};
    val = '{sb, mt, st, 8'($urandom)};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        tsfp_pkg::REG_START_BYTE:  regs_m.start_byte = val[i];
        tsfp_pkg::REG_MOTION_TYPE: regs_m.motion_type_code = val[i];
        tsfp_pkg::REG_STATUS_TYPE: regs_m.status_type_code = val[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Directed frames under the reset register values.
  task automatic test_default_registers();
    logic [7:0] body [tsfp_pkg::BODY_DEPTH];
    // A failed motion frame right after reset repeats the cleared held values.
    body = '{default: 8'h00};
    send_frame(tsfp_pkg::KIND_MOTION, body, 1'b1);
    // Signed extremes in both speed fields, values next to them in heading and turn rate.
    body = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h80,
             8'hFE, 8'h7F, 8'h00, 8'hFF, 8'h5A, 8'hA5};
    send_frame(tsfp_pkg::KIND_MOTION, body, 1'b0);
    // A failed motion frame repeats the values just held.
    random_body(body);
    send_frame(tsfp_pkg::KIND_MOTION, body, 1'b1);
    body = '{default: 8'hFF};
    send_frame(tsfp_pkg::KIND_STATUS, body, 1'b0);
    send_frame(tsfp_pkg::KIND_MOTION, body, 1'b0);
    // A failed status frame reports zeros.
    send_frame(tsfp_pkg::KIND_STATUS, body, 1'b1);
    // Stray bytes, an unknown type byte, then a start byte repeated before the type.
    send_byte(8'h33);
    send_byte(8'hFF);
    send_byte(regs_m.start_byte);
    send_byte(8'h07);
    send_byte(regs_m.start_byte);
    body = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
             8'h40, 8'h80, 8'h55, 8'hAA, 8'h00, 8'h00};
    send_frame(tsfp_pkg::KIND_STATUS, body, 1'b0);
  endtask

  // Register settings at the ends of their range, with codes that collide.
  task automatic test_register_extremes();
    logic [7:0] body [tsfp_pkg::BODY_DEPTH];
    // Start byte shared with the status type code.
    set_config(8'hFF, 8'h00, 8'hFF);
    random_body(body);
    send_frame(tsfp_pkg::KIND_MOTION, body, 1'b0);
    random_body(body);
    send_frame(tsfp_pkg::KIND_STATUS, body, 1'b0);
    // Equal type codes: the motion frame wins.
    set_config(8'h00, 8'hFF, 8'hFF);
    random_body(body);
    send_frame(tsfp_pkg::KIND_MOTION, body, 1'b0);
    random_body(body);
    send_frame(tsfp_pkg::KIND_MOTION, body, 1'b1);
    // Start byte doubling as the motion type code.
    set_config(8'hA5, 8'hA5, 8'h5A);
    random_body(body);
    send_frame(tsfp_pkg::KIND_MOTION, body, 1'b0);
    random_body(body);
    send_frame(tsfp_pkg::KIND_STATUS, body, 1'b0);
  endtask

  // The receiver holds off for a long stretch while bytes are offered with no gaps.
  task automatic test_output_backpressure();
    logic [7:0] body [tsfp_pkg::BODY_DEPTH];
    logic       kind;
    set_config(8'hC3, 8'h3C, 8'h96);
    in_idle_on = 1'b0;
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (16) begin
      random_body(body);
      kind = $urandom_range(1, 0);
      send_frame(kind, body, $urandom_range(5, 0) == 0);
    end
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // One random piece of traffic: mostly whole frames, some noise and broken framing.
  task automatic send_random_unit();
    logic [7:0] body [tsfp_pkg::BODY_DEPTH];
    int         pick;
    logic       kind;
    pick = $urandom_range(99, 0);
    kind = $urandom_range(1, 0);
    random_body(body);
    if (pick < 72) begin
      send_frame(kind, body, 1'b0);
    end else if (pick < 84) begin
      send_frame(kind, body, 1'b1);
    end else if (pick < 90) begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    end else if (pick < 94) begin
      send_byte(regs_m.start_byte);
      send_byte(8'($urandom));
    end else if (pick < 97) begin
      // A frame cut short; whatever follows lands in its body.
      send_byte(regs_m.start_byte);
      send_byte(kind ? regs_m.status_type_code : regs_m.motion_type_code);
      repeat ($urandom_range(6, 0)) send_byte(8'($urandom));
    end else begin
      send_byte(regs_m.start_byte);
      send_frame(kind, body, 1'b0);
    end
  endtask

  // Random traffic under several register settings.
  task automatic test_random_traffic(input int total);
    int quota;
    int goal;
    quota = total / 4;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_config(8'h00, 8'h01, 8'h02);
        1: set_config(8'($urandom), 8'($urandom), 8'($urandom));
        2: set_config(8'hFF, 8'h00, 8'h80);
        default: set_config(8'h55, 8'hAA, 8'($urandom_range(3, 0)));
      endcase
      goal = bytes_sent + quota;
      while (bytes_sent < goal) begin
        if ($urandom_range(39, 0) == 0) in_idle_on = !in_idle_on;
        if ($urandom_range(39, 0) == 0) out_idle_on = !out_idle_on;
        send_random_unit();
      end
    end
  endtask

  // Result receiver: a random stall before each transfer, plus long hold-offs on request.
  initial begin
    int gap;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        while (hold_cycles > 0) begin
          @(posedge clk);
          hold_cycles--;
        end
      end
      gap = out_idle_on ? $urandom_range(GAP_MAX, 0) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && hold_cycles == 0);
    end
  end

  // Compare each result transfer with the oldest expected frame.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("result with no frame pending", '0, '0);
      end else begin
        want_frame = expected_frames.pop_front();
        compare_field("frame_kind", frame_kind, want_frame.frame_kind);
        compare_field("sum_good", sum_good, want_frame.sum_good);
        compare_field("left_speed", $unsigned(left_speed), want_frame.left_speed);
        compare_field("right_speed", $unsigned(right_speed), want_frame.right_speed);
        compare_field("heading", $unsigned(heading), want_frame.heading);
        compare_field("turn_rate", $unsigned(turn_rate), want_frame.turn_rate);
        compare_field("sonar_ranges", sonar_ranges, want_frame.sonar_ranges);
        compare_field("status_bytes", status_bytes, want_frame.status_bytes);
        compare_field("spare_bytes", spare_bytes, want_frame.spare_bytes);
      end
    end
  end

  // Reset, the test sequence and the final verdict.
  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    regs_m = '{start_byte: 8'h00, motion_type_code: 8'h01, status_type_code: 8'h02};
    scan_phase = tsfp_pkg::PH_HUNT;
    body_pos = '0;
    cur_kind = tsfp_pkg::KIND_MOTION;
    sum_acc = '0;
    last_motion = '0;
    last_sonar = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_registers();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic(1450);
    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/tsfp_pkg.sv
src/tsfp_parse.sv
src/two_type_serial_frame_parser_unit.sv
src/tsfp_checker.sv
tb/testbench.sv
